### hw/rtl/nlq_pkg.sv
// ============================================================================
// nlq_pkg - neighbor link quality table shared definitions
// Field widths, register indexes, status codes and the table entry layout.
// ============================================================================
package nlq_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int NODE_W   = 16;
    localparam int LIFE_W   = 7;
    localparam int SEQ_W    = 8;
    localparam int HOP_W    = 8;
    localparam int AVG_W    = 8;
    localparam int GROUP_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int EXP_W    = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_GROUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIVE = 1'b1;

    localparam logic [GROUP_W-1:0] OWN_GROUP_RESET = 8'd0;
    localparam logic [LIFE_W-1:0]  FULL_LIVE_RESET = 7'd5;

    localparam logic [AVG_W-1:0] LINK_GAIN   = 8'd63;
    localparam logic [HOP_W-1:0] HOP_CLEARED = 8'h7f;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UPDATED     = 3'd0,
        STATUS_INSERTED    = 3'd1,
        STATUS_DROPPED     = 3'd2,
        STATUS_WRONG_GROUP = 3'd3,
        STATUS_TICK_DONE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LIFE_W-1:0] life;
        logic [SEQ_W-1:0]  seq;
        logic [HOP_W-1:0]  hop;
        logic [AVG_W-1:0]  link_avg;
        logic [AVG_W-1:0]  stable_avg;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_CLEARED = '{
        node:       '0,
        life:       '0,
        seq:        '0,
        hop:        HOP_CLEARED,
        link_avg:   '0,
        stable_avg: '0
    };

endpackage

### hw/rtl/nlq_if.sv
// ============================================================================
// nlq_if - request and result channels
// Valid/ready channels carrying one request item and one result item.
// ============================================================================
interface nlq_req_if;
    import nlq_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [NODE_W-1:0]  node_id;
    logic [SEQ_W-1:0]   seq_num;
    logic [HOP_W-1:0]   hop_count;
    logic [GROUP_W-1:0] group;

    modport source (output valid, opcode, node_id, seq_num, hop_count, group, input ready);
    modport sink   (input valid, opcode, node_id, seq_num, hop_count, group, output ready);
endinterface

interface nlq_rsp_if;
    import nlq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [AVG_W-1:0]    link_avg;
    logic [AVG_W-1:0]    stable_avg;
    logic [EXP_W-1:0]    expired_count;

    modport source (output valid, status, slot, link_avg, stable_avg, expired_count,
                    input ready);
    modport sink   (input valid, status, slot, link_avg, stable_avg, expired_count,
                    output ready);
endinterface

### hw/rtl/nlq_ram.sv
// ============================================================================
// nlq_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module nlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/neighbor_link_quality_table.sv
// ============================================================================
// neighbor_link_quality_table - neighbor table with link quality averages
// Per-node reception averages kept in one entry RAM, with a sequencer that
// scans, decays and writes back the matched entry, or ages every entry on a tick.
// ============================================================================
// Usage:
//   req channel (valid/ready): a received packet (opcode 0) or an aging tick
//   (opcode 1). rsp channel (valid/ready): exactly one result per request.
//   cfg_we/cfg_index/cfg_data write the own group id and full_liveliness;
//   write them only while no request is in flight.
// Processing per request:
//   wrong group      : no table access, the result is loaded directly
//   packet           : node lookup, then up to 17 decay steps
//                      (one per missed packet, stopping once the average
//                      settles below 4); the node lookup reads the entry RAM
//                      one entry per cycle
//   tick             : one read-modify-write per entry
//   One request is processed at a time; req.ready is high when the sequencer
//   is idle, also while an earlier result is still held in the output register.
// Reset clears all liveness flags, so every entry reads as free at once; no
// clearing pass over the RAM is needed. When rsp.ready is low the result stays
// in the output register and the next request can still be taken and worked on;
// its result waits until the register frees up.
// ============================================================================
module neighbor_link_quality_table #(
    parameter int TABLE_ENTRIES = nlq_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nlq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nlq_pkg::CFG_DATA_W-1:0]  cfg_data,
    nlq_req_if.sink                         req,
    nlq_rsp_if.source                       rsp
);
    import nlq_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECAY,
        S_WRITE,
        S_TICK,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [TABLE_ENTRIES-1:0] live_reg;
    logic [GROUP_W-1:0]       own_group_reg;
    logic [LIFE_W-1:0]        full_live_reg;

    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     rd_more_reg;
    logic                     pend_reg;
    logic [IDX_W-1:0]         pend_idx_reg;
    logic                     free_found_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic                     rsp_valid_reg;

    // request payload and working values
    logic [NODE_W-1:0]        node_reg;
    logic [SEQ_W-1:0]         seq_reg;
    logic [HOP_W-1:0]         hop_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic [AVG_W-1:0]         avg_reg;
    logic [AVG_W-1:0]         stable_reg;
    logic [LIFE_W-1:0]        cnt_reg;
    logic [EXP_W-1:0]         exp_reg;

    status_t                  res_status_reg;
    logic [SLOT_W-1:0]        res_slot_reg;
    logic [AVG_W-1:0]         res_link_reg;
    logic [AVG_W-1:0]         res_stable_reg;
    logic [EXP_W-1:0]         res_exp_reg;

    status_t                  out_status_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic [AVG_W-1:0]         out_link_reg;
    logic [AVG_W-1:0]         out_stable_reg;
    logic [EXP_W-1:0]         out_exp_reg;

    // RAM ports
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    entry_t                   ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    entry_t                   rd_entry;

    logic                     req_fire;
    logic                     rsp_load;
    logic                     pend_live;
    logic                     node_hit;
    logic                     last_pend;
    logic [SEQ_W-1:0]         seq_diff;
    logic [LIFE_W-1:0]        gap;
    logic [LIFE_W-1:0]        life_dec;
    logic                     decay_stop;
    logic [AVG_W-1:0]         avg_next;
    logic [AVG_W-1:0]         link_next;
    logic [AVG_W-1:0]         stable_next;
    logic [EXP_W-1:0]         exp_next;

    nlq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign req_fire  = req.valid && req.ready;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    assign pend_live = live_reg[pend_idx_reg];
    assign node_hit  = pend_reg && pend_live && (rd_entry.node == node_reg);
    assign last_pend = (pend_idx_reg == LAST_IDX);

    // sequence gap: difference mod 256 folded into 0..127
    assign seq_diff  = seq_reg - rd_entry.seq;
    assign gap       = seq_diff[LIFE_W-1:0];
    assign life_dec  = rd_entry.life - LIFE_W'(1);

    // below 4 the quarter decay no longer changes the average
    assign decay_stop  = (cnt_reg == '0) || (avg_reg[AVG_W-1:2] == '0);
    assign avg_next    = avg_reg - (avg_reg >> 2);
    assign link_next   = avg_next + LINK_GAIN;
    assign stable_next = stable_reg - (stable_reg >> 3) + (link_next >> 3);
    assign exp_next    = exp_reg + EXP_W'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_wdata = ENTRY_CLEARED;
        case (state_reg)
            S_WRITE:
            begin
                ram_we               = 1'b1;
                ram_waddr            = slot_reg;
                ram_wdata.node       = node_reg;
                ram_wdata.life       = full_live_reg;
                ram_wdata.seq        = seq_reg;
                ram_wdata.hop        = hop_reg;
                ram_wdata.link_avg   = link_next;
                ram_wdata.stable_avg = stable_next;
            end
            S_TICK:
            begin
                if (pend_reg && pend_live)
                begin
                    ram_we = 1'b1;
                    if (life_dec != '0)
                    begin
                        ram_wdata      = rd_entry;
                        ram_wdata.life = life_dec;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            live_reg        <= '0;
            own_group_reg   <= OWN_GROUP_RESET;
            full_live_reg   <= FULL_LIVE_RESET;
            rd_idx_reg      <= '0;
            rd_more_reg     <= 1'b0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_GROUP: own_group_reg <= cfg_data[GROUP_W-1:0];
                    CFG_FULL_LIVE: full_live_reg <= cfg_data[LIFE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // read issue pipeline shared by lookup and tick sweep
            if (state_reg == S_SCAN || state_reg == S_TICK)
            begin
                pend_reg     <= rd_more_reg;
                pend_idx_reg <= rd_idx_reg;
                rd_idx_reg   <= rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == LAST_IDX)
                begin
                    rd_more_reg <= 1'b0;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        rd_idx_reg     <= '0;
                        rd_more_reg    <= 1'b1;
                        pend_reg       <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (req.opcode == OP_TICK)
                        begin
                            state_reg <= S_TICK;
                        end
                        else if (req.group != own_group_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (pend_reg)
                    begin
                        if (node_hit)
                        begin
                            state_reg <= S_DECAY;
                        end
                        else if (last_pend)
                        begin
                            if (free_found_reg || !pend_live)
                            begin
                                state_reg <= S_DECAY;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else if (!pend_live && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= pend_idx_reg;
                        end
                    end
                end
                S_DECAY:
                begin
                    pend_reg <= 1'b0;
                    if (decay_stop)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    live_reg[slot_reg] <= (full_live_reg != '0);
                    state_reg          <= S_DONE;
                end
                S_TICK:
                begin
                    if (pend_reg)
                    begin
                        if (pend_live && life_dec == '0)
                        begin
                            live_reg[pend_idx_reg] <= 1'b0;
                        end
                        if (last_pend)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    pend_reg <= 1'b0;
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                node_reg       <= req.node_id;
                seq_reg        <= req.seq_num;
                hop_reg        <= req.hop_count;
                exp_reg        <= '0;
                res_status_reg <= (req.opcode == OP_TICK) ? STATUS_TICK_DONE
                                                          : STATUS_WRONG_GROUP;
                res_slot_reg   <= '0;
                res_link_reg   <= '0;
                res_stable_reg <= '0;
                res_exp_reg    <= '0;
            end
            S_SCAN:
            begin
                if (node_hit)
                begin
                    slot_reg       <= pend_idx_reg;
                    avg_reg        <= rd_entry.link_avg;
                    stable_reg     <= rd_entry.stable_avg;
                    cnt_reg        <= (gap == '0) ? '0 : gap - LIFE_W'(1);
                    res_status_reg <= STATUS_UPDATED;
                end
                else if (pend_reg && last_pend)
                begin
                    slot_reg       <= free_found_reg ? free_idx_reg : pend_idx_reg;
                    avg_reg        <= '0;
                    stable_reg     <= '0;
                    cnt_reg        <= '0;
                    res_status_reg <= (free_found_reg || !pend_live) ? STATUS_INSERTED
                                                                     : STATUS_DROPPED;
                end
            end
            S_DECAY:
            begin
                if (!decay_stop)
                begin
                    avg_reg <= avg_next;
                    cnt_reg <= cnt_reg - LIFE_W'(1);
                end
            end
            S_WRITE:
            begin
                res_slot_reg   <= SLOT_W'(slot_reg);
                res_link_reg   <= link_next;
                res_stable_reg <= stable_next;
            end
            S_TICK:
            begin
                if (pend_reg && pend_live && life_dec == '0)
                begin
                    exp_reg <= exp_next;
                end
                if (pend_reg && last_pend)
                begin
                    res_exp_reg <= (pend_live && life_dec == '0) ? exp_next : exp_reg;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    out_status_reg <= res_status_reg;
                    out_slot_reg   <= res_slot_reg;
                    out_link_reg   <= res_link_reg;
                    out_stable_reg <= res_stable_reg;
                    out_exp_reg    <= res_exp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.link_avg      = out_link_reg;
    assign rsp.stable_avg    = out_stable_reg;
    assign rsp.expired_count = out_exp_reg;

endmodule

### test/neighbor_link_quality_table_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// neighbor_link_quality_table_checker - result checker for the neighbor table
// Watches the request, result and register-write ports, keeps its own copy of
// the neighbor table, and compares every result with the predicted one.
// ============================================================================
module neighbor_link_quality_table_checker #(
    parameter int TABLE_ENTRIES = nlq_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nlq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nlq_pkg::CFG_DATA_W-1:0]  cfg_data,
    nlq_req_if                              req,
    nlq_rsp_if                              rsp,
    output int                              outstanding,
    output int                              mismatch_count
);
    import nlq_pkg::*;

    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [AVG_W-1:0]   link_avg;
        logic [AVG_W-1:0]   stable_avg;
        logic [EXP_W-1:0]   expired_count;
    } nbr_result_t;

    entry_t             neighbors [TABLE_ENTRIES];
    logic [GROUP_W-1:0] own_group;
    logic [LIFE_W-1:0]  full_live;
    nbr_result_t        expected_results [$];

    // Applies one request to the table copy and returns the result it yields.
    function automatic nbr_result_t update_neighbors(
        input logic              op,
        input logic [NODE_W-1:0] node,
        input logic [SEQ_W-1:0]  seq,
        input logic [HOP_W-1:0]  hop,
        input logic [GROUP_W-1:0] grp
    );
        nbr_result_t       res;
        logic [SEQ_W-1:0]  diff;
        int                hit;
        int                gap;
        int                avg;
        int                stab;
        int                k;
        int                i;
        res.status        = STATUS_TICK_DONE;
        res.slot          = '0;
        res.link_avg      = '0;
        res.stable_avg    = '0;
        res.expired_count = '0;
        if (op == OP_TICK) begin
            for (k = 0; k < TABLE_ENTRIES; k++) begin
                if (neighbors[k].life != 0) begin
                    neighbors[k].life = neighbors[k].life - 1'b1;
                    if (neighbors[k].life == 0) begin
                        neighbors[k] = ENTRY_CLEARED;
                        res.expired_count = res.expired_count + 1'b1;
                    end
                end
            end
            return res;
        end
        if (grp != own_group) begin
            res.status = STATUS_WRONG_GROUP;
            return res;
        end
        // only live entries match; a dead slot is free whatever node it holds
        hit = -1;
        for (k = 0; k < TABLE_ENTRIES; k++)
            if (hit < 0 && neighbors[k].life != 0 && neighbors[k].node == node)
                hit = k;
        if (hit >= 0) begin
            diff = seq - neighbors[hit].seq;
            gap  = diff[SEQ_W-1] ? int'(diff) - 128 : int'(diff);
            avg  = int'(neighbors[hit].link_avg);
            stab = int'(neighbors[hit].stable_avg);
            res.status = STATUS_UPDATED;
        end else begin
            for (k = 0; k < TABLE_ENTRIES; k++)
                if (hit < 0 && neighbors[k].life == 0)
                    hit = k;
            if (hit < 0) begin
                res.status = STATUS_DROPPED;
                return res;
            end
            neighbors[hit].node = node;
            gap  = 1;
            avg  = 0;
            stab = 0;
            res.status = STATUS_INSERTED;
        end
        // one quarter decay per missed packet, then one more plus the gain
        for (i = 2; i <= gap; i++)
            avg = avg - (avg >> 2);
        avg  = (avg - (avg >> 2) + int'(LINK_GAIN)) & 8'hff;
        stab = (stab - (stab >> 3) + (avg >> 3)) & 8'hff;
        neighbors[hit].life       = full_live;
        neighbors[hit].seq        = seq;
        neighbors[hit].hop        = hop;
        neighbors[hit].link_avg   = avg[AVG_W-1:0];
        neighbors[hit].stable_avg = stab[AVG_W-1:0];
        res.slot       = hit[SLOT_W-1:0];
        res.link_avg   = avg[AVG_W-1:0];
        res.stable_avg = stab[AVG_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        nbr_result_t want;
        int          k;
        if (!rst_n) begin
            for (k = 0; k < TABLE_ENTRIES; k++)
                neighbors[k] = ENTRY_CLEARED;
            own_group = OWN_GROUP_RESET;
            full_live = FULL_LIVE_RESET;
            expected_results.delete();
            outstanding    = 0;
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_OWN_GROUP)
                    own_group = cfg_data[GROUP_W-1:0];
                else if (cfg_index == CFG_FULL_LIVE)
                    full_live = cfg_data[LIFE_W-1:0];
            end
            if (req.valid && req.ready)
                expected_results.push_back(update_neighbors(req.opcode, req.node_id,
                                                            req.seq_num, req.hop_count,
                                                            req.group));
            if (rsp.valid && rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", rsp.status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, rsp.status);
                    compare_field("slot", want.slot, rsp.slot);
                    compare_field("link_avg", want.link_avg, rsp.link_avg);
                    compare_field("stable_avg", want.stable_avg, rsp.stable_avg);
                    compare_field("expired_count", want.expired_count, rsp.expired_count);
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

### test/neighbor_link_quality_table_test.sv
`timescale 1ns / 1ps
// ============================================================================
// neighbor_link_quality_table_test - testbench top for the neighbor table
// Drives packet and tick requests with random gaps and result-side stalls,
// moves through several register settings, and reports the checker verdict.
// ============================================================================
module neighbor_link_quality_table_test;
    import nlq_pkg::*;

    localparam int POOL_MAX      = 24;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES_DEF + 24;
    localparam int PHASE_ITEMS   = 400;
    localparam int NUM_PHASES    = 5;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     outstanding;
    int                     mismatch_count;

    logic [NODE_W-1:0]      node_pool [POOL_MAX];
    logic [SEQ_W-1:0]       pool_seq [POOL_MAX];
    int                     pool_size;
    logic [GROUP_W-1:0]     cur_group;
    bit                     send_burst;
    bit                     take_burst;

    nlq_req_if req_ch ();
    nlq_rsp_if rsp_ch ();

    neighbor_link_quality_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    neighbor_link_quality_table_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("neighbor_link_quality_table: mismatch");
        $finish;
    end

    // result side: random stall before taking each result, with calm stretches
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        take_burst   = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    task automatic send_req(input logic op, input logic [NODE_W-1:0] node,
                            input logic [SEQ_W-1:0] seq, input logic [HOP_W-1:0] hop,
                            input logic [GROUP_W-1:0] grp);
        int idle;
        if ($urandom_range(0, 49) == 0)
            send_burst = !send_burst;
        idle = send_burst ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (idle > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.node_id   <= node;
        req_ch.seq_num   <= seq;
        req_ch.hop_count <= hop;
        req_ch.group     <= grp;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // hold off until every request has its result, then let the sequencer settle
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pool_packet(input int idx, input logic [GROUP_W-1:0] grp);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            pool_seq[idx] = pool_seq[idx] + 8'd1;
        else if (r < 75)
            pool_seq[idx] = pool_seq[idx] + 8'($urandom_range(2, 20));
        else if (r < 85)
            pool_seq[idx] = pool_seq[idx] + 8'($urandom_range(128, 255));
        else if (r < 92)
            pool_seq[idx] = 8'($urandom_range(0, 255));
        // otherwise the sequence repeats
        send_req(OP_PACKET, node_pool[idx], pool_seq[idx], 8'($urandom_range(0, 255)), grp);
    endtask

    initial
    begin
        logic [GROUP_W-1:0] phase_group [NUM_PHASES];
        logic [LIFE_W-1:0]  phase_live [NUM_PHASES];
        int                 phase_ticks [NUM_PHASES];
        int                 p;
        int                 k;
        int                 r;

        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_PACKET;
        req_ch.node_id   = '0;
        req_ch.seq_num   = '0;
        req_ch.hop_count = '0;
        req_ch.group     = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_OWN_GROUP;
        cfg_data         = '0;
        send_burst       = 1'b0;
        cur_group        = OWN_GROUP_RESET;
        rst_n            = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, group 0 and liveness 5
        send_req(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);      // tick on empty table
        send_req(OP_PACKET, 16'h0000, 8'h00, 8'h00, 8'h00);    // node 0 inserted
        send_req(OP_PACKET, 16'h0000, 8'h00, 8'hff, 8'h00);    // repeated sequence
        send_req(OP_PACKET, 16'h0000, 8'h01, 8'h01, 8'h00);
        send_req(OP_PACKET, 16'h0000, 8'd17, 8'h10, 8'h00);    // many missed packets
        send_req(OP_PACKET, 16'h0000, 8'hff, 8'h80, 8'h00);    // sequence went backward
        send_req(OP_PACKET, 16'h0000, 8'h01, 8'h02, 8'hff);    // wrong group
        send_req(OP_PACKET, 16'hffff, 8'h80, 8'h7f, 8'h00);
        for (k = 1; k <= 14; k++)
            send_req(OP_PACKET, 16'(k), 8'(k), 8'(k), 8'h00);
        send_req(OP_PACKET, 16'h1234, 8'h55, 8'haa, 8'h00);    // table full
        send_req(OP_TICK, 16'hffff, 8'hff, 8'hff, 8'hff);

        phase_group[0] = 8'hff;  phase_live[0] = 7'd127;  phase_ticks[0] = 2;
        phase_group[1] = 8'h00;  phase_live[1] = 7'd1;    phase_ticks[1] = 20;
        phase_group[2] = 8'($urandom_range(1, 254));
        phase_live[2]  = 7'($urandom_range(2, 10));       phase_ticks[2] = 10;
        phase_group[3] = 8'h5a;  phase_live[3] = 7'd3;    phase_ticks[3] = 6;
        phase_group[4] = 8'($urandom_range(0, 255));
        phase_live[4]  = 7'($urandom_range(1, 127));      phase_ticks[4] = 8;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_reg(CFG_OWN_GROUP, phase_group[p]);
            write_reg(CFG_FULL_LIVE, {1'b0, phase_live[p]});
            cur_group = phase_group[p];

            // fresh neighbor set of 10 to POOL_MAX nodes; it can hold more nodes than slots
            pool_size    = $urandom_range(10, POOL_MAX);
            node_pool[0] = 16'h0000;
            node_pool[1] = 16'hffff;
            for (k = 2; k < POOL_MAX; k++)
                node_pool[k] = 16'($urandom_range(0, 65535));
            for (k = 0; k < POOL_MAX; k++)
                pool_seq[k] = 8'($urandom_range(0, 255));

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
                r = $urandom_range(0, 99);
                if (r < phase_ticks[p])
                    send_req(OP_TICK, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                else if (r < phase_ticks[p] + 4)
                    send_req(OP_PACKET, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                else if (r < phase_ticks[p] + 8)
                    send_pool_packet($urandom_range(0, pool_size - 1),
                                     cur_group ^ 8'($urandom_range(1, 255)));
                else
                    send_pool_packet($urandom_range(0, pool_size - 1), cur_group);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("neighbor_link_quality_table: match");
        else
            $display("neighbor_link_quality_table: mismatch");
        $finish;
    end

endmodule
